// ===== src/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for the signature substring scanner
// Field widths, stream packing offsets and request codes.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int BYTE_W = 8;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 6;
    localparam int CFG_W  = 5;
    localparam int CNT_W  = 32;

    // slave tdata: sig_slot, byte_pos, byte_value from bit 0 up, zero fill to 24
    localparam int S_TDATA_W = 24;
    localparam int SLOT_LSB  = 0;
    localparam int POS_LSB   = SLOT_LSB + SLOT_W;
    localparam int VALUE_LSB = POS_LSB + POS_W;
    localparam int S_USED_W  = VALUE_LSB + BYTE_W;

    // master tdata: file_matched, files_scanned, files_infected, zero fill to 72
    localparam int M_TDATA_W    = 72;
    localparam int MATCHED_LSB  = 0;
    localparam int SCANNED_LSB  = 1;
    localparam int INFECTED_LSB = SCANNED_LSB + CNT_W;
    localparam int M_USED_W     = INFECTED_LSB + CNT_W;

    // request kinds carried on slave tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_count;

endpackage

// ===== src/signature_substring_scanner.sv =====
// ----------------------------------------------------------------------------
// signature_substring_scanner: multi-signature substring search over files
// Stores signatures and a sliding byte window; flags files that contain one.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one item per handshake. tuser = 0 loads one signature
//   byte (tlast on the final byte sets the slot length), tuser = 1 presents one
//   file byte (tlast on the last byte of the file). Every item gives exactly one
//   result item on the master stream: current match flag, tlast set when the
//   item closed a file, and the saturating scanned / infected counters.
//   i_cfg_we / i_cfg_wdata set how many slots, from slot 0, are searched.
//   A load goes straight to its result; a file byte first scans the searched
//   slots, one slot compared per cycle: a row read of the signature memory,
//   a byte alignment shift set by the slot length, then a compare against
//   the newest slot-length bytes of the window. s_axis_tready is low from
//   accept until the result is loaded into the output register.
//   A result waiting on a stalled receiver does not block accepting the next
//   item; that item's result waits for the output register to empty.
//   Reset clears slot lengths, window fill, match flag, counters and the
//   output valid flag; signature memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module signature_substring_scanner
    import sss_pkg::*;
#(
    parameter int NUM_SIGS = 16,
    parameter int MAX_LEN  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // sig_slot[3:0], byte_pos[9:4], byte_value[17:10]
    input  logic                 s_axis_tuser,   // req_type
    input  logic                 s_axis_tlast,   // last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // file_matched[0], files_scanned[32:1],
                                                 // files_infected[64:33]
    output logic                 m_axis_tlast    // file_end
);

    localparam int SW = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(NUM_SIGS + 2);
    localparam int RW = BYTE_W * MAX_LEN;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       act_cnt;
    logic [CFG_W-1:0]    r_active;
    logic                r_req_data, r_last;

    logic [RW-1:0]       r_pat_mem [NUM_SIGS];
    logic [LW-1:0]       r_len [NUM_SIGS];

    logic [RW-1:0]       r_win;
    logic [RW+BYTE_W-1:0] win_ext;
    logic [LW-1:0]       r_fill;
    logic                r_match;

    logic                r_v1, r_v2;
    logic [RW-1:0]       r_row;
    logic [LW-1:0]       r_row_len;
    logic [LW-1:0]       shift_amt;
    logic [RW-1:0]       r_al;
    logic [MAX_LEN-1:0]  r_mask;
    logic                r_ok;
    logic                hit;

    t_count              r_scanned, r_infected;
    logic                r_out_valid, r_out_matched, r_out_end;

    logic [SLOT_W-1:0]   in_slot;
    logic [POS_W-1:0]    in_pos;
    t_byte               in_value;
    logic                in_acc, load_ok, load_wr;
    logic [SW-1:0]       wr_row, rd_idx;
    logic [PW-1:0]       wr_byte;
    logic                issue, emit, file_done;

    assign in_slot  = s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign in_pos   = s_axis_tdata[POS_LSB +: POS_W];
    assign in_value = s_axis_tdata[VALUE_LSB +: BYTE_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign load_ok  = (int'(in_slot) < NUM_SIGS) && (int'(in_pos) < MAX_LEN);
    assign load_wr  = in_acc && (s_axis_tuser == REQ_LOAD) && load_ok;
    assign wr_row   = SW'(in_slot);
    assign wr_byte  = PW'(in_pos);
    assign act_cnt  = (r_active > NUM_SIGS) ? CW'(NUM_SIGS) : CW'(r_active);
    assign rd_idx   = r_cnt[SW-1:0];
    assign issue    = (r_state == ST_SCAN) && (r_cnt < act_cnt);
    assign emit     = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);
    assign file_done = emit && r_req_data && r_last;
    assign win_ext  = {in_value, r_win};

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cnt   = '0;
                    n_state = (s_axis_tuser == REQ_DATA) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                // last compare lands after the row read and align registers
                if (r_cnt == act_cnt + CW'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_active <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req_data <= (s_axis_tuser == REQ_DATA);
            r_last     <= s_axis_tlast;
        end
    end

    // signature memory: one row per slot, byte writes, registered row read
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_pat_mem[wr_row][BYTE_W*wr_byte +: BYTE_W] <= in_value;
        end
        r_row <= r_pat_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SIGS; i++) begin
                r_len[i] <= '0;
            end
        end else if (load_wr && s_axis_tlast) begin
            r_len[wr_row] <= LW'(in_pos) + LW'(1);
        end
    end

    // window: newest byte in the top byte lane
    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == REQ_DATA)) begin
            r_win <= win_ext[RW+BYTE_W-1:BYTE_W];
        end
    end

    // compare pipeline: length read, align, compare
    assign shift_amt = LW'(MAX_LEN) - r_row_len;

    always_ff @(posedge i_clk) begin
        r_row_len <= r_len[rd_idx];
        r_al      <= r_row << (BYTE_W * shift_amt);
        r_mask    <= {MAX_LEN{1'b1}} << shift_amt;
        r_ok      <= (r_row_len != '0) && (r_row_len <= r_fill);
    end

    always_comb begin
        hit = r_ok;
        for (int j = 0; j < MAX_LEN; j++) begin
            if (r_mask[j] && (r_al[BYTE_W*j +: BYTE_W] != r_win[BYTE_W*j +: BYTE_W])) begin
                hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_fill     <= '0;
            r_match    <= 1'b0;
            r_scanned  <= '0;
            r_infected <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (in_acc && (s_axis_tuser == REQ_DATA) && (r_fill != LW'(MAX_LEN))) begin
                r_fill <= r_fill + LW'(1);
            end
            if (r_v2 && hit) begin
                r_match <= 1'b1;
            end
            if (file_done) begin
                r_fill  <= '0;
                r_match <= 1'b0;
                if (r_scanned != '1) begin
                    r_scanned <= r_scanned + 1'b1;
                end
                if (r_match && (r_infected != '1)) begin
                    r_infected <= r_infected + 1'b1;
                end
            end
        end
    end

    // output register; counters only move when a new result loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_matched <= r_match;
            r_out_end     <= r_req_data && r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_end;
    assign m_axis_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, r_infected, r_scanned, r_out_matched};

endmodule

// ===== src/sss_chk.sv =====
// ----------------------------------------------------------------------------
// sss_chk: port-level checks for the signature substring scanner
// Watches handshakes and result counters; bound to the top level.
// ----------------------------------------------------------------------------
module sss_chk
    import sss_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    t_count scanned, infected;

    assign scanned  = m_axis_tdata[SCANNED_LSB +: CNT_W];
    assign infected = m_axis_tdata[INFECTED_LSB +: CNT_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    a_infected_le_scanned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> infected <= scanned)
        else $error("infected count above scanned count");

    a_end_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> scanned != '0)
        else $error("file end with zero scanned count");

endmodule

bind signature_substring_scanner sss_chk u_sss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_signature_substring_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signature_substring_scanner: self-checking bench for the signature scanner
// Loads signatures and streams files through the slave port, predicts every
// result item with a behavioral scanner model, and checks the master stream
// under random source and sink stalls, and with none.
// ----------------------------------------------------------------------------
module tb_signature_substring_scanner;
    import sss_pkg::*;

    localparam int SLOTS         = 16;
    localparam int WIN           = 64;
    localparam int SETTLE_CYCLES = 24;     // longest item is a file byte with all slots searched
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic              req;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        t_byte             value;
        logic              last;
    } scan_item_t;

    typedef struct packed {
        logic   matched;
        logic   file_end;
        t_count scanned;
        t_count infected;
    } verdict_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;    // sig_slot, byte_pos, byte_value
    logic                 s_axis_tuser  = 1'b0;  // req_type
    logic                 s_axis_tlast  = 1'b0;  // last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;          // file_matched, files_scanned,
                                                 // files_infected
    logic                 m_axis_tlast;          // file_end

    // scanner model state
    t_byte       sig_bytes   [SLOTS][WIN];
    bit          sig_written [SLOTS][WIN];
    int unsigned sig_len     [SLOTS];
    t_byte       window      [WIN];               // index WIN-1 is the newest byte
    int unsigned window_fill;
    bit          file_hit;
    t_count      scanned_cnt;
    t_count      infected_cnt;
    int unsigned slots_searched;

    verdict_t    expected_q[$];
    int unsigned src_idle_pct  = 32;
    int unsigned sink_idle_pct = 71;
    int unsigned items_sent;
    int          fail_count    = 0;
    int unsigned stall_cycles  = 0;

    signature_substring_scanner #(
        .NUM_SIGS(SLOTS),
        .MAX_LEN (WIN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one accepted item to the model and returns its result.
    function automatic verdict_t scan_byte(input scan_item_t it);
        verdict_t    res;
        int unsigned n;
        int unsigned len;
        bit          same;
        res = '0;
        if (it.req == REQ_LOAD) begin
            sig_bytes[it.slot][it.pos]   = it.value;
            sig_written[it.slot][it.pos] = 1'b1;
            if (it.last)
                sig_len[it.slot] = it.pos + 1;
        end else begin
            n = (slots_searched > SLOTS) ? SLOTS : slots_searched;
            for (int i = 0; i < WIN - 1; i++)
                window[i] = window[i + 1];
            window[WIN - 1] = it.value;
            if (window_fill < WIN)
                window_fill++;
            for (int s = 0; s < n; s++) begin
                len = sig_len[s];
                if (len != 0 && len <= window_fill) begin
                    same = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (sig_bytes[s][i] != window[WIN - len + i])
                            same = 1'b0;
                    if (same)
                        file_hit = 1'b1;
                end
            end
        end
        res.matched = file_hit;
        if (it.req == REQ_DATA && it.last) begin
            res.file_end = 1'b1;
            if (scanned_cnt != '1)
                scanned_cnt++;
            if (file_hit && infected_cnt != '1)
                infected_cnt++;
            file_hit    = 1'b0;
            window_fill = 0;
            foreach (window[i])
                window[i] = '0;
        end
        res.scanned  = scanned_cnt;
        res.infected = infected_cnt;
        return res;
    endfunction

    // Mostly a narrow alphabet so signatures turn up by chance too.
    function automatic t_byte pick_byte();
        if ($urandom_range(4) == 0)
            return t_byte'($urandom_range(255));
        return t_byte'(8'h60 + $urandom_range(7));
    endfunction

    task automatic send_item(input scan_item_t it);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[SLOT_LSB +: SLOT_W]  = it.slot;
        word[POS_LSB +: POS_W]    = it.pos;
        word[VALUE_LSB +: BYTE_W] = it.value;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= it.req;
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(scan_byte(it));
        items_sent++;
    endtask

    task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] pos,
                             input t_byte value, input logic last);
        scan_item_t it;
        it.req   = REQ_LOAD;
        it.slot  = slot;
        it.pos   = pos;
        it.value = value;
        it.last  = last;
        send_item(it);
    endtask

    task automatic send_data(input t_byte value, input logic last);
        scan_item_t it;
        it.req   = REQ_DATA;
        it.slot  = SLOT_W'($urandom_range(SLOTS - 1));   // don't-care on data items
        it.pos   = POS_W'($urandom_range(WIN - 1));
        it.value = value;
        it.last  = last;
        send_item(it);
    endtask

    task automatic load_signature(input int unsigned slot, input t_byte bytes[$]);
        foreach (bytes[i])
            send_load(SLOT_W'(slot), POS_W'(i), bytes[i], i == bytes.size() - 1);
    endtask

    // Stray load; only closes a signature whose lower bytes are all written.
    task automatic send_stray_load();
        int unsigned slot;
        int unsigned pos;
        bit          closable;
        slot     = $urandom_range(SLOTS - 1);
        pos      = $urandom_range(WIN - 1);
        closable = 1'b1;
        for (int i = 0; i < pos; i++)
            if (!sig_written[slot][i])
                closable = 1'b0;
        send_load(SLOT_W'(slot), POS_W'(pos), t_byte'($urandom_range(255)),
                  closable && $urandom_range(3) == 0);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_active_slots(input logic [CFG_W-1:0] count);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slots_searched = count;
    endtask

    task automatic load_random_signature();
        t_byte       bytes[$];
        int unsigned len;
        case ($urandom_range(19))
            0:       len = WIN;
            1, 2:    len = $urandom_range(9, WIN - 1);
            default: len = $urandom_range(1, 8);
        endcase
        repeat (len) bytes.push_back(pick_byte());
        load_signature($urandom_range(SLOTS - 1), bytes);
    endtask

    task automatic send_random_file();
        t_byte       body[$];
        int unsigned len;
        int unsigned slot;
        int unsigned slen;
        int unsigned at;
        len = ($urandom_range(9) == 0) ? $urandom_range(WIN + 1, 120) : $urandom_range(1, 24);
        repeat (len) body.push_back(pick_byte());
        // plant a stored signature so hits are common
        if ($urandom_range(1) == 1) begin
            slot = $urandom_range(SLOTS - 1);
            slen = sig_len[slot];
            if (slen != 0 && slen <= len) begin
                at = $urandom_range(len - slen);
                for (int i = 0; i < slen; i++)
                    body[at + i] = sig_bytes[slot][i];
            end
        end
        foreach (body[i]) begin
            if ($urandom_range(19) == 0)
                send_stray_load();
            send_data(body[i], i == body.size() - 1);
        end
    endtask

    // No slot searched after reset: files pass clean, counters move.
    task automatic test_no_active_slots();
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
    endtask

    task automatic test_basic_matches();
        load_signature(0, '{8'hAB});
        load_signature(15, '{8'h00, 8'hFF});
        send_load(SLOT_W'(3), POS_W'(WIN - 1), 8'h5A, 1'b0);   // top position, slot stays empty
        write_active_slots(5'd31);                    // clamps to all slots
        send_data(8'h00, 1'b0);
        send_load(SLOT_W'(7), POS_W'(0), 8'h3C, 1'b0);   // load mid-file reports the flag
        send_data(8'hFF, 1'b0);
        send_data(8'h11, 1'b1);                       // flag held to end of file
        send_data(8'hAB, 1'b1);                       // one-byte file, one-byte signature
    endtask

    task automatic test_reload_and_short_window();
        send_load(SLOT_W'(15), POS_W'(1), 8'h77, 1'b0);   // length stays 2
        send_data(8'h77, 1'b1);                       // bytes from the previous file must not count
        send_data(8'h00, 1'b0);
        send_data(8'h77, 1'b1);
    endtask

    task automatic test_slot_selection();
        write_active_slots(5'd1);
        send_data(8'h00, 1'b0);
        send_data(8'h77, 1'b1);                       // slot 15 not searched
        write_active_slots(5'(SLOTS));
        send_data(8'hAB, 1'b0);
        send_data(8'h12, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            case ($urandom_range(7))
                0: begin
                    case ($urandom_range(4))
                        0:       write_active_slots('0);
                        1:       write_active_slots(5'(SLOTS));
                        2:       write_active_slots(5'($urandom_range(SLOTS + 1, 31)));
                        default: write_active_slots(5'($urandom_range(1, SLOTS)));
                    endcase
                end
                1, 2:    load_random_signature();
                default: send_random_file();
            endcase
        end
    endtask

    always @(posedge i_clk) begin : result_check
        verdict_t got;
        verdict_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.matched  = m_axis_tdata[MATCHED_LSB];
            got.file_end = m_axis_tlast;
            got.scanned  = m_axis_tdata[SCANNED_LSB +: CNT_W];
            got.infected = m_axis_tdata[INFECTED_LSB +: CNT_W];
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: matched=%0b end=%0b scanned=%0d infected=%0d",
                             got.matched, got.file_end, got.scanned, got.infected);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result mismatch: expected matched=%0b end=%0b scanned=%0d infected=%0d",
                                 want.matched, want.file_end, want.scanned, want.infected);
                        $display("                 got      matched=%0b end=%0b scanned=%0d infected=%0d",
                                 got.matched, got.file_end, got.scanned, got.infected);
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (sig_len[s]) begin
            sig_len[s] = 0;
            foreach (sig_bytes[s][i]) begin
                sig_bytes[s][i]   = '0;
                sig_written[s][i] = 1'b0;
            end
        end
        foreach (window[i])
            window[i] = '0;
        window_fill    = 0;
        file_hit       = 1'b0;
        scanned_cnt    = '0;
        infected_cnt   = '0;
        slots_searched = 0;
        items_sent     = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_active_slots();
        test_basic_matches();
        test_reload_and_short_window();
        test_slot_selection();
        test_random_traffic(700);

        src_idle_pct  = 71;
        sink_idle_pct = 32;
        test_random_traffic(700);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(600);

        wait_results_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
